// ===== design/mcg_pkg.sv =====
// shared types, constants and the control store for the month calendar grid
// no dependencies; every other file of the block imports it

package mcg_pkg;

  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;
  localparam int ColW   = 3;
  localparam int RowW   = 3;
  localparam int CellW  = 6;
  localparam int StepW  = 4;

  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMax = 4'd12;

  // reciprocal constants for the shared multiplier
  localparam logic [15:0] Recip100 = 16'd41944;  // ceil(2^22 / 100)
  localparam logic [15:0] Recip7   = 16'd37450;  // ceil(2^18 / 7)

  localparam logic [CellW-1:0] GridCellsShort = 6'd35;
  localparam logic [CellW-1:0] LastCellShort  = 6'd34;
  localparam logic [CellW-1:0] LastCellLong   = 6'd41;
  localparam logic [ColW-1:0]  LastCol        = 3'd6;

  typedef logic [StepW-1:0] step_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_PREP,
    OP_QYR,
    OP_QY,
    OP_MUL7,
    OP_MOD7,
    OP_GRID,
    OP_EMIT,
    OP_NOP,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    C_NEXT,
    C_BAD,
    C_MORE,
    C_ALWAYS
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic hold;
    logic bad_month;
    logic more;
  } stat_t;

  localparam step_t StepIdle = 4'd0;
  localparam step_t StepEmit = 4'd7;
  localparam step_t StepBad  = 4'd9;

  // control store
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    unique case (s)
      4'd0:    w = '{op: OP_IDLE, cond: C_NEXT,   target: StepIdle};
      4'd1:    w = '{op: OP_PREP, cond: C_BAD,    target: StepBad};
      4'd2:    w = '{op: OP_QYR,  cond: C_NEXT,   target: StepIdle};
      4'd3:    w = '{op: OP_QY,   cond: C_NEXT,   target: StepIdle};
      4'd4:    w = '{op: OP_MUL7, cond: C_NEXT,   target: StepIdle};
      4'd5:    w = '{op: OP_MOD7, cond: C_NEXT,   target: StepIdle};
      4'd6:    w = '{op: OP_GRID, cond: C_NEXT,   target: StepIdle};
      4'd7:    w = '{op: OP_EMIT, cond: C_MORE,   target: StepEmit};
      4'd8:    w = '{op: OP_NOP,  cond: C_ALWAYS, target: StepIdle};
      4'd9:    w = '{op: OP_BAD,  cond: C_ALWAYS, target: StepIdle};
      default: w = '{op: OP_NOP,  cond: C_ALWAYS, target: StepIdle};
    endcase
    return w;
  endfunction

  // (31 * m) / 12 term of the weekday formula, m counted from march
  function automatic logic [4:0] month_offset(input logic [MonthW-1:0] mo);
    logic [4:0] r;
    case (mo)
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd2;
      4'd4:    r = 5'd5;
      4'd5:    r = 5'd7;
      4'd6:    r = 5'd10;
      4'd7:    r = 5'd12;
      4'd8:    r = 5'd15;
      4'd9:    r = 5'd18;
      4'd10:   r = 5'd20;
      4'd11:   r = 5'd23;
      4'd12:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] mo);
    logic [DayW-1:0] r;
    case (mo)
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      4'd2:                    r = 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

// ===== design/mcg_in_if.sv =====
// request channel of the month calendar grid: year and month
// depends on mcg_pkg for the field widths

interface mcg_in_if;
  import mcg_pkg::*;

  logic              valid;
  logic              ready;
  logic [YearW-1:0]  year;
  logic [MonthW-1:0] month;

  modport source (output valid, year, month, input ready);
  modport sink (input valid, year, month, output ready);
endinterface

// ===== design/mcg_out_if.sv =====
// result channel of the month calendar grid: one grid cell per beat
// depends on mcg_pkg for the field widths

interface mcg_out_if;
  import mcg_pkg::*;

  logic            valid;
  logic            ready;
  logic [DayW-1:0] day_number;
  logic [ColW-1:0] weekday_column;
  logic [RowW-1:0] week_row;
  logic            bad_input;
  logic            last_cell;

  modport source (output valid, day_number, weekday_column, week_row, bad_input, last_cell,
                  input ready);
  modport sink (input valid, day_number, weekday_column, week_row, bad_input, last_cell,
                output ready);
endinterface

// ===== design/mcg_sequencer.sv =====
// step counter and control store lookup for the month calendar grid
// depends on mcg_pkg for the control word and the program

module mcg_sequencer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mcg_pkg::stat_t stat_i,
  output mcg_pkg::ctrl_t ctrl_o
);
  import mcg_pkg::*;

  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  jump;

  always_comb begin
    ctrl = ucode(step_q);
    unique case (ctrl.cond)
      C_NEXT:   jump = 1'b0;
      C_BAD:    jump = stat_i.bad_month;
      C_MORE:   jump = stat_i.more;
      C_ALWAYS: jump = 1'b1;
      default:  jump = 1'b0;
    endcase
    if (stat_i.hold) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = ctrl.target;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;
endmodule

// ===== design/mcg_datapath.sv =====
// datapath of the month calendar grid: request latch, shared reciprocal
// multiplier, weekday and length registers, cell counters and output register
// depends on mcg_pkg and the two channel interfaces

module mcg_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mcg_pkg::ctrl_t ctrl_i,
  output mcg_pkg::stat_t stat_o,
  mcg_in_if.sink         in_i,
  mcg_out_if.source      out_o
);
  import mcg_pkg::*;

  logic [YearW-1:0]  yr_q;
  logic [MonthW-1:0] mo_q;
  logic [14:0]       y_q;
  logic [14:0]       sum_q;
  logic [30:0]       mult_q;
  logic              leap_q;
  logic [2:0]        first_q;
  logic [DayW-1:0]   len_q;
  logic [CellW-1:0]  k_q, last_k_q;
  logic [ColW-1:0]   col_q;
  logic [RowW-1:0]   row_q;
  logic              out_valid_q;
  logic [DayW-1:0]   day_q;
  logic [ColW-1:0]   ocol_q;
  logic [RowW-1:0]   orow_q;
  logic              bad_q, last_q;

  logic              ready, accept, slot_free, bad_month, shift, mult_en;
  logic [14:0]       y_new, mult_a, rem7;
  logic [15:0]       mult_k;
  logic [7:0]        q100;
  logic [11:0]       q7;
  logic [13:0]       hundreds;
  logic [6:0]        diff;
  logic [DayW-1:0]   day_val;
  logic [CellW-1:0]  tot;
  logic              emit_go, bad_go;

  assign ready     = (ctrl_i.op == OP_IDLE);
  assign accept    = in_i.valid && ready;
  assign slot_free = !out_valid_q || out_o.ready;
  assign bad_month = (mo_q == '0) || (mo_q > MonthMax);
  assign shift     = (mo_q <= MonthFeb);
  assign emit_go   = (ctrl_i.op == OP_EMIT) && slot_free;
  assign bad_go    = (ctrl_i.op == OP_BAD) && slot_free;

  // year shifted by a whole 400-year cycle, january and february count to the prior year
  assign y_new    = {1'b0, yr_q} + 15'd400 - {14'b0, shift};
  assign q100     = mult_q[29:22];
  assign q7       = mult_q[29:18];
  assign hundreds = 14'({6'b0, q100} * 14'd100);
  assign rem7     = sum_q - 15'({3'b0, q7} * 15'd7);
  assign diff     = {1'b0, k_q} - {4'b0, first_q};
  assign day_val  = (!diff[6] && (diff[5:0] < {1'b0, len_q})) ? DayW'(diff[4:0] + 5'd1) : '0;
  assign tot      = {3'b0, first_q} + {1'b0, len_q};

  always_comb begin
    mult_en = 1'b1;
    mult_a  = {1'b0, yr_q};
    mult_k  = Recip100;
    case (ctrl_i.op)
      OP_PREP: mult_a = {1'b0, yr_q};
      OP_QYR:  mult_a = y_q;
      OP_MUL7: begin
        mult_a = sum_q;
        mult_k = Recip7;
      end
      default: mult_en = 1'b0;
    endcase
  end

  always_comb begin
    stat_o.bad_month = bad_month;
    stat_o.more      = (k_q != last_k_q);
    case (ctrl_i.op)
      OP_IDLE:        stat_o.hold = !in_i.valid;
      OP_EMIT, OP_BAD: stat_o.hold = !slot_free;
      default:        stat_o.hold = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_go || bad_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      yr_q <= in_i.year;
      mo_q <= in_i.month;
    end
    if (mult_en) begin
      mult_q <= mult_a * {15'b0, mult_k};
    end
    case (ctrl_i.op)
      OP_PREP: begin
        y_q   <= y_new;
        sum_q <= 15'd1 + y_new + {2'b0, y_new[14:2]} + {10'b0, month_offset(mo_q)};
      end
      OP_QYR: begin
        // leap test on the request year itself
        if (yr_q == hundreds) begin
          leap_q <= (q100[1:0] == 2'b00);
        end else begin
          leap_q <= (yr_q[1:0] == 2'b00);
        end
      end
      OP_QY: begin
        sum_q <= sum_q - {7'b0, q100} + {9'b0, q100[7:2]};
      end
      OP_MOD7: begin
        first_q <= rem7[2:0];
        if (mo_q == MonthFeb) begin
          len_q <= leap_q ? 5'd29 : 5'd28;
        end else begin
          len_q <= month_days(mo_q);
        end
      end
      OP_GRID: begin
        last_k_q <= (tot > GridCellsShort) ? LastCellLong : LastCellShort;
        k_q      <= '0;
        col_q    <= '0;
        row_q    <= '0;
      end
      default: ;
    endcase
    if (emit_go) begin
      day_q  <= day_val;
      ocol_q <= col_q;
      orow_q <= row_q;
      bad_q  <= 1'b0;
      last_q <= (k_q == last_k_q);
      k_q    <= k_q + CellW'(1);
      if (col_q == LastCol) begin
        col_q <= '0;
        row_q <= row_q + RowW'(1);
      end else begin
        col_q <= col_q + ColW'(1);
      end
    end else if (bad_go) begin
      day_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
      bad_q  <= 1'b1;
      last_q <= 1'b1;
    end
  end

  assign in_i.ready           = ready;
  assign out_o.valid          = out_valid_q;
  assign out_o.day_number     = day_q;
  assign out_o.weekday_column = ocol_q;
  assign out_o.week_row       = orow_q;
  assign out_o.bad_input      = bad_q;
  assign out_o.last_cell      = last_q;
endmodule

// ===== design/month_calendar_grid.sv =====
// top level of the month calendar grid: sequencer plus datapath
// depends on mcg_pkg, mcg_in_if, mcg_out_if, mcg_sequencer and mcg_datapath

// One request (year, month) is taken while the block is idle; it then works
// on that request alone. Six setup steps follow, three of them passes through
// the one shared reciprocal multiplier (year / 100 for the leap test, shifted
// year / 100 and the sum mod 7 for the weekday). The grid then leaves one
// cell per cycle while the sink takes beats, 35 or 42 cells, and one closing
// step returns to idle. A month outside 1 to 12 gives a single flagged beat
// and then returns to idle. The output register lets the last beat wait while
// the next request is accepted.

module month_calendar_grid (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcg_in_if.sink    in_i,
  mcg_out_if.source out_o
);
  import mcg_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  mcg_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  mcg_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .in_i   (in_i),
    .out_o  (out_o)
  );
endmodule

// ===== design/mcg_checker.sv =====
// port-level checks for the month calendar grid, bound to the top level
// depends on mcg_pkg for the field widths

module mcg_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [mcg_pkg::DayW-1:0] out_day_number_i,
  input logic [mcg_pkg::RowW-1:0] out_week_row_i,
  input logic                   out_bad_input_i,
  input logic                   out_last_cell_i
);
  import mcg_pkg::*;

  // busy right after a request beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous one still in work");

  // no new request until the last cell has gone out
  a_busy_mid_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_cell_i |=> !in_ready_i)
    else $error("ready raised before the grid was finished");

  // a stalled cell holds
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_day_number_i)
      && $stable(out_week_row_i) && $stable(out_last_cell_i))
    else $error("stalled cell changed");

  // a bad month gives one blank closing cell
  a_bad_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_bad_input_i |-> out_last_cell_i && (out_day_number_i == '0)
      && (out_week_row_i == '0))
    else $error("bad-month beat malformed");
endmodule

bind month_calendar_grid mcg_checker u_mcg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_day_number_i (out_o.day_number),
  .out_week_row_i   (out_o.week_row),
  .out_bad_input_i  (out_o.bad_input),
  .out_last_cell_i  (out_o.last_cell)
);
